// File: hdl/dpbpc_pkg.sv
`default_nettype none
package dpbpc_pkg;
  localparam int ADC_BITS_DEF = 12;
  localparam int RANGE_TOL_DEF = 150;
  localparam int MAX_DISAGREE_DEF = 150;
  localparam int QW = 11;   // quotient bits of a lane divider; larger quotients saturate at 2047

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CH1_HIGH = 3'd1;
  localparam logic [2:0] ST_CH1_LOW  = 3'd2;
  localparam logic [2:0] ST_CH2_HIGH = 3'd3;
  localparam logic [2:0] ST_CH2_LOW  = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  localparam logic [2:0] REG_MIN1  = 3'd0;
  localparam logic [2:0] REG_MAX1  = 3'd1;
  localparam logic [2:0] REG_MIN2  = 3'd2;
  localparam logic [2:0] REG_MAX2  = 3'd3;
  localparam logic [2:0] REG_DUAL  = 3'd4;
  localparam logic [2:0] REG_INV   = 3'd5;
  localparam logic [2:0] REG_RMIN  = 3'd6;
  localparam logic [2:0] REG_RMAX  = 3'd7;

  // One lane result: truncated per mille, clamped to 0..1000, with out-of-range flags.
  typedef struct packed {
    logic hi;                 // above 1000 + tolerance
    logic lo;                 // below -tolerance
    logic [9:0] clamped;      // 0..1000
  } lane_res_t;
endpackage
`default_nettype wire

// File: hdl/dpbpc_lane.sv
`default_nettype none
// Pipelined restoring divider: (raw - lo) * 1000 / (hi - lo), truncating toward zero.
// One quotient bit per stage, QW stages, then one classification stage.
module dpbpc_lane #(
  parameter int ADC_BITS = dpbpc_pkg::ADC_BITS_DEF,
  parameter int RANGE_TOL = dpbpc_pkg::RANGE_TOL_DEF
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [ADC_BITS-1:0] raw,
  input  wire logic [ADC_BITS-1:0] lo,
  input  wire logic [ADC_BITS-1:0] hi,
  output dpbpc_pkg::lane_res_t     res
);
  import dpbpc_pkg::*;
  localparam int NW = ADC_BITS + 11;   // |num| < 2^ADC_BITS * 1024
  localparam int DW = ADC_BITS + 1;

  logic [NW-1:0] num_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          neg_r [QW+1];
  logic          zero_r[QW+1];

  logic signed [ADC_BITS:0] dnum, dden;
  logic signed [NW:0] prod;
  always_comb begin
    dnum = $signed({1'b0, raw}) - $signed({1'b0, lo});
    dden = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = NW'(dnum) * $signed((NW+1)'(1000));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= prod[NW] ? NW'(-prod) : prod[NW-1:0];
      den_r[0]  <= dden[ADC_BITS] ? DW'(-dden) : DW'(dden);
      neg_r[0]  <= prod[NW] ^ dden[ADC_BITS];
      zero_r[0] <= (dden == '0);
      q_r[0]    <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [NW:0] trial;
    logic [NW:0] dsh;
    always_comb begin
      dsh   = (NW+1)'(den_r[s]) << B;
      trial = {1'b0, num_r[s]} - dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s+1]  <= trial[NW] ? num_r[s] : trial[NW-1:0];
        q_r[s+1]    <= q_r[s] | (trial[NW] ? '0 : QW'(1) << B);
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  logic [QW-1:0] mag;
  logic ishi, islo;
  always_comb begin
    mag  = zero_r[QW] ? '0 : q_r[QW];
    ishi = !neg_r[QW] && (32'(mag) > 32'(1000 + RANGE_TOL));
    islo = neg_r[QW] && (32'(mag) > 32'(RANGE_TOL));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res.hi <= ishi;
      res.lo <= islo;
      res.clamped <= (neg_r[QW] || mag == '0) ? 10'd0 :
                     (mag > QW'(1000)) ? 10'd1000 : mag[9:0];
    end
  end
endmodule
`default_nettype wire

// File: hdl/dpbpc_merge.sv
`default_nettype none
// Combines the three lanes into status, pedal and regen, in two stages.
// The regen division by 1000 is a reciprocal multiply on the product magnitude.
module dpbpc_merge #(
  parameter int MAX_DISAGREE = dpbpc_pkg::MAX_DISAGREE_DEF
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire dpbpc_pkg::lane_res_t l1,
  input  wire dpbpc_pkg::lane_res_t l2,
  input  wire dpbpc_pkg::lane_res_t lp,
  input  wire logic           dual,
  input  wire logic           inv,
  input  wire logic           pedal_off,
  input  wire logic [6:0]     rmin,
  input  wire logic [6:0]     rmax,
  output logic [2:0]          status,
  output logic [9:0]          pedal,
  output logic signed [10:0]  regen
);
  import dpbpc_pkg::*;
  // ceil(2^31 / 1000): exact floor division for every magnitude below 2^21.
  localparam logic [21:0] RECIP_1000 = 22'd2147484;

  logic [2:0] st_nxt, st_r;
  logic [9:0] ped_nxt, ped_r;
  logic signed [12:0] d;
  logic signed [12:0] sum;
  logic signed [7:0] rspan;
  logic [6:0] rabs;
  logic [10:0] rspan10;
  logic [20:0] pmag_nxt, pmag_r;
  logic pneg_r;
  logic [6:0] rmin_r;
  logic [42:0] qprod;
  logic [11:0] qmag;
  logic [10:0] rmin10;
  logic signed [12:0] qs, rg;
  logic [2:0] status_r;
  logic [9:0] pedal_r;
  logic signed [10:0] regen_r;

  always_comb begin
    sum = 13'sd1000 - $signed({3'b0, l1.clamped}) - $signed({3'b0, l2.clamped});
    d   = $signed({3'b0, l1.clamped}) - $signed({3'b0, l2.clamped});
    priority if (l1.hi) st_nxt = ST_CH1_HIGH;
    else if (l1.lo) st_nxt = ST_CH1_LOW;
    else if (!dual) st_nxt = ST_OK;
    else if (l2.hi) st_nxt = ST_CH2_HIGH;
    else if (l2.lo) st_nxt = ST_CH2_LOW;
    else if (inv && (sum > 13'(MAX_DISAGREE) || sum < -13'(MAX_DISAGREE)))
      st_nxt = ST_MISMATCH;
    else if (!inv && (d > 13'(MAX_DISAGREE) || d < -13'(MAX_DISAGREE)))
      st_nxt = ST_MISMATCH;
    else st_nxt = ST_OK;
    ped_nxt = (pedal_off || lp.clamped < 10'd15) ? 10'd0 : lp.clamped;
    // The regen product is kept as a magnitude plus the sign of the span.
    rspan    = $signed({1'b0, rmax}) - $signed({1'b0, rmin});
    rabs     = rspan[7] ? 7'(-rspan) : 7'(rspan);
    rspan10  = 11'(rabs) * 11'd10;
    pmag_nxt = 21'(rspan10) * 21'(ped_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r   <= st_nxt;
      ped_r  <= ped_nxt;
      pmag_r <= pmag_nxt;
      pneg_r <= rspan[7];
      rmin_r <= rmin;
    end
  end

  always_comb begin
    qprod  = 43'(pmag_r) * 43'(RECIP_1000);
    qmag   = qprod[42:31];
    rmin10 = 11'(rmin_r) * 11'd10;
    qs     = $signed({1'b0, qmag});
    rg     = (pneg_r ? qs : -qs) - $signed({2'b0, rmin10});
    if (rg > 13'sd1000) rg = 13'sd1000;
    if (rg < -13'sd1000) rg = -13'sd1000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= st_r;
      pedal_r  <= ped_r;
      regen_r  <= rg[10:0];
    end
  end

  assign status = status_r;
  assign pedal  = pedal_r;
  assign regen  = regen_r;
endmodule
`default_nettype wire

// File: hdl/dual_pot_brake_pedal_checker_unit.sv
// Throughput: one word per cycle, set by the three pipelined dividers, while
// no result word is held by out_stall.
// The whole pipeline advances when its last stage is empty or being taken.
// Reset (synchronous, rst_n low) clears the valid bits and loads the
// calibration registers with their defaults.
`default_nettype none
module dual_pot_brake_pedal_checker_unit #(
  parameter int RANGE_TOL = dpbpc_pkg::RANGE_TOL_DEF,
  parameter int MAX_DISAGREE = dpbpc_pkg::MAX_DISAGREE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_raw_first,
  input  wire logic [11:0] in_raw_second,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_signal_ok,
  output logic [2:0]       out_status_code,
  output logic [9:0]       out_pedal_per_mille,
  output logic signed [10:0] out_regen_level,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import dpbpc_pkg::*;
  localparam int LAT = QW + 4;
  // The sample and level widths are fixed by the register map.
  localparam int ADC_BITS = ADC_BITS_DEF;

  // Calibration and regen registers.
  logic [11:0] min1_r, max1_r, min2_r, max2_r;
  logic dual_r, inv_r;
  logic [6:0] rmin_r, rmax_r;
  logic [2:0] ridx;
  logic wr;
  assign ridx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min1_r <= 12'd409; max1_r <= 12'd3681;
      min2_r <= 12'd409; max2_r <= 12'd3681;
      dual_r <= 1'b1; inv_r <= 1'b0; rmin_r <= '0; rmax_r <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_MIN1: min1_r <= cfg_pwdata[11:0];
        REG_MAX1: max1_r <= cfg_pwdata[11:0];
        REG_MIN2: min2_r <= cfg_pwdata[11:0];
        REG_MAX2: max2_r <= cfg_pwdata[11:0];
        REG_DUAL: dual_r <= cfg_pwdata[0];
        REG_INV:  inv_r  <= cfg_pwdata[0];
        REG_RMIN: rmin_r <= cfg_pwdata[6:0];
        REG_RMAX: rmax_r <= cfg_pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MIN1: cfg_prdata = {20'b0, min1_r};
      REG_MAX1: cfg_prdata = {20'b0, max1_r};
      REG_MIN2: cfg_prdata = {20'b0, min2_r};
      REG_MAX2: cfg_prdata = {20'b0, max2_r};
      REG_DUAL: cfg_prdata = {31'b0, dual_r};
      REG_INV:  cfg_prdata = {31'b0, inv_r};
      REG_RMIN: cfg_prdata = {25'b0, rmin_r};
      REG_RMAX: cfg_prdata = {25'b0, rmax_r};
    endcase
  end

  // Pipeline valid bits; all stages move together.
  logic [LAT-1:0] vld_r;
  logic adv;
  assign adv = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !adv;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  // The pedal lane clamps channel one to the calibration before dividing.
  logic [11:0] cpl;
  always_comb begin
    if (in_raw_first < min1_r) cpl = min1_r;
    else if (in_raw_first > max1_r) cpl = max1_r;
    else cpl = in_raw_first;
  end

  lane_res_t l1, l2, lp;
  dpbpc_lane #(.ADC_BITS(ADC_BITS), .RANGE_TOL(RANGE_TOL)) u_l1 (
    .clk, .en(adv), .raw(ADC_BITS'(in_raw_first)), .lo(ADC_BITS'(min1_r)),
    .hi(ADC_BITS'(max1_r)), .res(l1));
  dpbpc_lane #(.ADC_BITS(ADC_BITS), .RANGE_TOL(RANGE_TOL)) u_l2 (
    .clk, .en(adv), .raw(ADC_BITS'(in_raw_second)), .lo(ADC_BITS'(min2_r)),
    .hi(ADC_BITS'(max2_r)), .res(l2));
  dpbpc_lane #(.ADC_BITS(ADC_BITS), .RANGE_TOL(RANGE_TOL)) u_lp (
    .clk, .en(adv), .raw(ADC_BITS'(cpl)), .lo(ADC_BITS'(min1_r)),
    .hi(ADC_BITS'(max1_r)), .res(lp));

  // The user must keep configuration static while items are in flight; the block does not enforce it.
  logic [2:0] status;
  dpbpc_merge #(.MAX_DISAGREE(MAX_DISAGREE)) u_merge (
    .clk, .en(adv), .l1, .l2, .lp, .dual(dual_r), .inv(inv_r),
    .pedal_off(max1_r == '0), .rmin(rmin_r), .rmax(rmax_r),
    .status, .pedal(out_pedal_per_mille), .regen(out_regen_level));

  assign out_valid = vld_r[LAT-1];
  assign out_status_code = status;
  assign out_signal_ok = (status == ST_OK);

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status_code))
    else $error("result word changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status_code <= ST_MISMATCH)
    else $error("bad status");
`endif
endmodule
`default_nettype wire

// File: tb/sv/tb_dual_pot_brake_pedal_checker_unit.sv
`default_nettype none
module tb_dual_pot_brake_pedal_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dpbpc_pkg::*;

  // One result word of the pedal checker, as it leaves the block.
  typedef struct {
    logic              ok;
    logic [2:0]        status;
    logic [9:0]        pedal;
    logic signed [10:0] regen;
  } pedal_word_t;

  // One row of the directed table. When pinned is set, the expected word is
  // typed in below; otherwise the predictor supplies it.
  typedef struct {
    int          setting;
    int          raw1;
    int          raw2;
    bit          pinned;
    pedal_word_t word;
  } pedal_row_t;

  // Calibration and regen settings, one entry per phase of the run.
  typedef struct {
    int min1, max1, min2, max2, dual, inv, rmin, rmax;
  } pedal_cal_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [11:0] in_raw_first;
  logic [11:0] in_raw_second;
  logic out_valid;
  logic out_stall;
  logic out_signal_ok;
  logic [2:0] out_status_code;
  logic [9:0] out_pedal_per_mille;
  logic signed [10:0] out_regen_level;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  dual_pot_brake_pedal_checker_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_raw_first(in_raw_first), .in_raw_second(in_raw_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_signal_ok(out_signal_ok), .out_status_code(out_status_code),
    .out_pedal_per_mille(out_pedal_per_mille), .out_regen_level(out_regen_level),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // The testbench's own copy of the calibration registers.
  pedal_cal_t cal;

  // Words predicted for accepted samples, oldest first.
  pedal_word_t pending_words[$];

  int  fail_count = 0;
  int  words_seen = 0;
  int  status_hits[6];
  bit  hold_request = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung pipeline.
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  // Scales a raw sample to per mille, truncating toward zero; a zero span
  // gives zero.
  function automatic int scale_per_mille(int raw, int lo, int hi);
    if (hi == lo) return 0;
    return (raw - lo) * 1000 / (hi - lo);
  endfunction

  // Works out the word the block should give for one sample pair under the
  // current calibration.
  function automatic pedal_word_t predict_pedal(int raw1, int raw2);
    pedal_word_t w;
    logic [2:0] st;
    int p1, p2, pos, clip, span, regen;
    st = ST_OK;
    p1 = scale_per_mille(raw1, cal.min1, cal.max1);
    if (p1 > 1000 + RANGE_TOL_DEF) st = ST_CH1_HIGH;
    else if (p1 < -RANGE_TOL_DEF) st = ST_CH1_LOW;
    else begin
      p1 = (p1 > 1000) ? 1000 : (p1 < 0 ? 0 : p1);
      if (cal.dual != 0) begin
        p2 = scale_per_mille(raw2, cal.min2, cal.max2);
        if (p2 > 1000 + RANGE_TOL_DEF) st = ST_CH2_HIGH;
        else if (p2 < -RANGE_TOL_DEF) st = ST_CH2_LOW;
        else begin
          p2 = (p2 > 1000) ? 1000 : (p2 < 0 ? 0 : p2);
          if (cal.inv != 0) begin
            if (((1000 - p1 - p2) > MAX_DISAGREE_DEF) ||
                ((1000 - p1 - p2) < -MAX_DISAGREE_DEF)) st = ST_MISMATCH;
          end else if (p1 - MAX_DISAGREE_DEF > p2 || p2 - MAX_DISAGREE_DEF > p1) begin
            st = ST_MISMATCH;
          end
        end
      end
    end
    // Pedal position: channel one clamped into its calibration, with the
    // deadband at the bottom. A zero maximum disables the pedal.
    if (cal.max1 == 0) pos = 0;
    else begin
      clip = raw1;
      if (clip < cal.min1) clip = cal.min1;
      else if (clip > cal.max1) clip = cal.max1;
      pos = scale_per_mille(clip, cal.min1, cal.max1);
      if (pos < 0) pos = 0;
      if (pos > 1000) pos = 1000;
      if (pos < 15) pos = 0;
    end
    span = cal.rmax - cal.rmin;
    regen = -10 * span * pos / 1000 - 10 * cal.rmin;
    if (regen > 1000) regen = 1000;
    if (regen < -1000) regen = -1000;
    w.ok = (st == ST_OK);
    w.status = st;
    w.pedal = pos[9:0];
    w.regen = regen[10:0];
    return w;
  endfunction

  // Result side: compare every accepted word with the oldest expectation.
  always @(posedge clk) begin
    pedal_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (out_status_code < 6) status_hits[out_status_code]++;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_signal_ok !== want.ok) begin
          $error("signal_ok: expected %0d, got %0d", want.ok, out_signal_ok);
          fail_count++;
        end
        if (out_status_code !== want.status) begin
          $error("status_code: expected %0d, got %0d", want.status, out_status_code);
          fail_count++;
        end
        if (out_pedal_per_mille !== want.pedal) begin
          $error("pedal_per_mille: expected %0d, got %0d", want.pedal,
                 out_pedal_per_mille);
          fail_count++;
        end
        if (out_regen_level !== want.regen) begin
          $error("regen_level: expected %0d, got %0d", want.regen, out_regen_level);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall: it switches between no stall, light, half and heavy stalling,
  // and on request holds off for a long stretch so the pipeline backs up.
  initial begin
    int mode, left, hold_left;
    out_stall = 0;
    mode = 0;
    left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = 400;
        hold_request <= 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 120);
        end
        left--;
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // One APB write: setup cycle, then access cycle; pready is always high.
  // The bus is left selected so that writes can follow each other; the
  // caller releases it after the last one.
  task automatic write_reg(logic [2:0] index, int value);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
  endtask

  task automatic load_calibration(pedal_cal_t c);
    write_reg(REG_MIN1, c.min1);
    write_reg(REG_MAX1, c.max1);
    write_reg(REG_MIN2, c.min2);
    write_reg(REG_MAX2, c.max2);
    write_reg(REG_DUAL, c.dual);
    write_reg(REG_INV, c.inv);
    write_reg(REG_RMIN, c.rmin);
    write_reg(REG_RMAX, c.rmax);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
    cal = c;
  endtask

  // Lowers valid and waits until every expected word has arrived.
  task automatic drain_pipeline();
    in_valid <= 0;
    wait (pending_words.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Offers one sample pair and returns once it has been accepted. Valid is
  // left high so that a burst runs back to back; the caller lowers it.
  task automatic send_word(int raw1, int raw2, bit pinned, pedal_word_t typed);
    in_valid <= 1;
    in_raw_first <= raw1[11:0];
    in_raw_second <= raw2[11:0];
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    pending_words = {pending_words, (pinned ? typed : predict_pedal(raw1, raw2))};
  endtask

  function automatic int clamp_adc(int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  // Raw sample at a given travel (per mille, may run past the ends) of a track.
  function automatic int raw_at(int travel, int lo, int hi);
    return clamp_adc(lo + (hi - lo) * travel / 1000);
  endfunction

  initial begin
    pedal_row_t  directed[$];
    pedal_cal_t  phases[8];
    pedal_cal_t  narrow;
    pedal_word_t none;
    int setting, burst, travel, travel2, r1, r2;
    in_valid = 0;
    in_raw_first = 0;
    in_raw_second = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    rst_n = 0;
    none = '{0, 0, 0, 0};
    cal = '{409, 3681, 409, 3681, 1, 0, 0, 0};
    narrow = '{1000, 2000, 1000, 2000, 1, 0, 20, 80};

    // Directed rows. Setting 0 is the reset calibration; setting 1 is a narrow
    // calibration on which every range fault can be reached.
    directed = '{
      '{0, 409, 409, 1, '{1, ST_OK, 10'd0, 11'sd0}},
      '{0, 3681, 3681, 1, '{1, ST_OK, 10'd1000, 11'sd0}},
      '{0, 3681, 409, 1, '{0, ST_MISMATCH, 10'd1000, 11'sd0}},
      '{0, 0, 0, 0, none},
      '{0, 4095, 4095, 0, none},
      '{0, 4095, 0, 0, none},
      '{0, 2000, 2400, 0, none},
      '{0, 458, 458, 0, none},
      '{1, 4095, 0, 1, '{0, ST_CH1_HIGH, 10'd1000, -11'sd800}},
      '{1, 0, 4095, 1, '{0, ST_CH1_LOW, 10'd0, -11'sd200}},
      '{1, 1500, 4095, 1, '{0, ST_CH2_HIGH, 10'd500, -11'sd500}},
      '{1, 1500, 0, 1, '{0, ST_CH2_LOW, 10'd500, -11'sd500}},
      '{1, 1500, 1500, 1, '{1, ST_OK, 10'd500, -11'sd500}},
      '{1, 1014, 1014, 0, none},
      '{1, 1015, 1015, 0, none},
      '{1, 1151, 1000, 0, none},
      '{1, 2150, 2150, 0, none},
      '{1, 2151, 2000, 0, none},
      '{1, 849, 1000, 0, none},
      '{1, 850, 1000, 0, none},
      '{1, 1300, 1451, 0, none},
      '{1, 2000, 4095, 0, none}
    };

    // Random phases: reset values, full-scale tracks, inverted and reversed
    // tracks, zero spans, a disabled pedal, a single sensor and regen extremes.
    phases[0] = '{409, 3681, 409, 3681, 1, 0, 0, 0};
    phases[1] = '{0, 4095, 0, 4095, 1, 0, 0, 100};
    phases[2] = '{1000, 2000, 3000, 1000, 1, 1, 20, 80};
    phases[3] = '{2000, 1000, 500, 500, 1, 0, 100, 0};
    phases[4] = '{500, 0, 409, 3681, 1, 0, 127, 127};
    phases[5] = '{409, 3681, 0, 0, 0, 1, 10, 127};
    phases[6] = '{700, 700, 4095, 0, 1, 1, 0, 127};
    phases[7] = '{100, 3900, 3900, 100, 1, 1, 50, 50};

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    setting = 0;
    foreach (directed[i]) begin
      if (directed[i].setting != setting) begin
        drain_pipeline();
        load_calibration(narrow);
        setting = directed[i].setting;
      end
      send_word(directed[i].raw1, directed[i].raw2, directed[i].pinned,
                directed[i].word);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end

    foreach (phases[p]) begin
      drain_pipeline();
      load_calibration(phases[p]);
      if (p == 2) hold_request <= 1;
      for (int n = 0; n < 180; n = n + burst) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 9) < 7) begin
            // A coherent pair: both tracks at about the same travel.
            travel = $urandom_range(0, 1400) - 200;
            travel2 = (cal.inv != 0) ? 1000 - travel : travel;
            travel2 = travel2 + $urandom_range(0, 400) - 200;
            r1 = raw_at(travel, cal.min1, cal.max1);
            r2 = raw_at(travel2, cal.min2, cal.max2);
          end else begin
            r1 = $urandom_range(0, 4095);
            r2 = $urandom_range(0, 4095);
          end
          send_word(r1, r2, 0, none);
        end
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end

    drain_pipeline();
    $display("Checked %0d result words over %0d calibration phases.", words_seen, 10);
    $display("Status counts ok/ch1hi/ch1lo/ch2hi/ch2lo/mismatch: %0d %0d %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
